// ----- rtl/core/cdsd_pkg.sv -----
`timescale 1ns / 1ps

package cdsd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DELTA,
        PH_FLAGS,
        PH_CODE,
        PH_DONE
    } phase_t;

    localparam logic [2:0] REC_HEADER = 3'd0;

    localparam logic [1:0] SEC_STATIC   = 2'd0;
    localparam logic [1:0] SEC_INSTANCE = 2'd1;
    localparam logic [1:0] SEC_DIRECT   = 2'd2;
    localparam logic [1:0] SEC_VIRTUAL  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [31:0] member_index;
        logic [31:0] entry_flags;
        logic [31:0] code_offset;
        logic [31:0] static_count;
        logic [31:0] instance_count;
        logic [31:0] direct_count;
        logic [31:0] virtual_count;
        logic [4:0]  record_bytes;
        logic [31:0] bytes_consumed;
        logic        last_of_item;
    } out_word_t;

endpackage

// ----- rtl/core/class_data_uleb_stream_decoder.sv -----
`timescale 1ns / 1ps

// Class data item decoder: takes one byte of the item per cycle on the byte channel while
// byte_ready is high and emits one word on the record channel for the header (four section
// counts) and for each field or method entry, with its running member index, flags, code
// offset and byte lengths. A byte with first_byte set restarts the parser; bytes before the
// first item and after the item ends are dropped. Parser state and any record register on the
// edge that ends the accepting cycle, the record going to the output register, or to the skid
// register when the output register holds a record not taken. This two-deep output stage lets
// bytes keep flowing while a record waits; byte_ready falls only when both hold a record.
module class_data_uleb_stream_decoder
    import cdsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_word_t  byte_data,
    output logic      rec_valid,
    input  logic      rec_ready,
    output out_word_t rec_data
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  sec_reg, sec_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  pos_reg, pos_next;
    logic [31:0] sizes_reg [4];
    logic [31:0] sizes_next [4];
    logic [31:0] remain_reg, remain_next;
    logic [31:0] index_reg, index_next;
    logic [31:0] flags_reg, flags_next;
    logic [31:0] item_cnt_reg, item_cnt_next;
    logic [4:0]  rec_cnt_reg, rec_cnt_next;

    out_word_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   skid_reg, skid_next;
    logic        skid_valid_reg, skid_valid_next;

    // working copies after a possible restart
    phase_t      ph_c;
    logic [1:0]  sec_c;
    logic [31:0] acc_c;
    logic [2:0]  pos_c;
    logic [31:0] item_c;
    logic [4:0]  rec_c;

    logic        accept;
    logic        active;
    logic [31:0] merged;
    logic        done;
    logic [31:0] val;
    logic        push;
    out_word_t   res;
    logic        pop;

    logic [31:0] srch_sizes [4];
    logic [2:0]  srch_from;
    logic        srch_found;
    logic [1:0]  srch_sec;

    assign accept     = byte_valid && byte_ready;
    assign byte_ready = !skid_valid_reg;
    assign rec_valid  = out_valid_reg;
    assign rec_data   = out_reg;
    assign pop        = out_valid_reg && rec_ready;

    always_comb
    begin
        if (byte_data.first_byte)
        begin
            ph_c   = PH_HEADER;
            sec_c  = SEC_STATIC;
            acc_c  = 32'd0;
            pos_c  = 3'd0;
            item_c = 32'd0;
            rec_c  = 5'd0;
        end
        else
        begin
            ph_c   = phase_reg;
            sec_c  = sec_reg;
            acc_c  = acc_reg;
            pos_c  = pos_reg;
            item_c = item_cnt_reg;
            rec_c  = rec_cnt_reg;
        end

        active = accept && (ph_c != PH_IDLE) && (ph_c != PH_DONE);

        case (pos_c)
            3'd0: merged = acc_c | {25'd0, byte_data.data_byte[6:0]};
            3'd1: merged = acc_c | {18'd0, byte_data.data_byte[6:0], 7'd0};
            3'd2: merged = acc_c | {11'd0, byte_data.data_byte[6:0], 14'd0};
            3'd3: merged = acc_c | {4'd0, byte_data.data_byte[6:0], 21'd0};
            default: merged = acc_c | {byte_data.data_byte[3:0], 28'd0};
        endcase
        done = (pos_c >= 3'd4) || !byte_data.data_byte[7];
        val  = merged;

        // next non-empty section: from zero after the header, else after the current one
        for (int i = 0; i < 4; i++)
        begin
            srch_sizes[i] = sizes_reg[i];
        end
        if (ph_c == PH_HEADER)
        begin
            srch_sizes[3] = val;
            srch_from     = 3'd0;
        end
        else
        begin
            srch_from = {1'b0, sec_c} + 3'd1;
        end
        srch_found = 1'b0;
        srch_sec   = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if ((3'(i) >= srch_from) && (srch_sizes[i] != 32'd0))
            begin
                srch_found = 1'b1;
                srch_sec   = 2'(i);
            end
        end

        phase_next    = phase_reg;
        sec_next      = sec_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        for (int i = 0; i < 4; i++)
        begin
            sizes_next[i] = sizes_reg[i];
        end
        remain_next   = remain_reg;
        index_next    = index_reg;
        flags_next    = flags_reg;
        item_cnt_next = item_cnt_reg;
        rec_cnt_next  = rec_cnt_reg;
        push          = 1'b0;
        res           = '0;

        if (accept && byte_data.first_byte)
        begin
            phase_next    = ph_c;
            sec_next      = sec_c;
            acc_next      = acc_c;
            pos_next      = pos_c;
            item_cnt_next = item_c;
            rec_cnt_next  = rec_c;
        end

        if (active)
        begin
            item_cnt_next = item_c + 32'd1;
            rec_cnt_next  = rec_c + 5'd1;
            res.record_bytes   = rec_c + 5'd1;
            res.bytes_consumed = item_c + 32'd1;
            if (!done)
            begin
                acc_next = merged;
                pos_next = pos_c + 3'd1;
            end
            else
            begin
                acc_next = 32'd0;
                pos_next = 3'd0;
                case (ph_c)
                    PH_HEADER:
                    begin
                        sizes_next[sec_c] = val;
                        if (sec_c != SEC_VIRTUAL)
                        begin
                            sec_next = sec_c + 2'd1;
                        end
                        else
                        begin
                            push                = 1'b1;
                            res.record_kind     = REC_HEADER;
                            res.static_count    = sizes_reg[0];
                            res.instance_count  = sizes_reg[1];
                            res.direct_count    = sizes_reg[2];
                            res.virtual_count   = val;
                        end
                    end
                    PH_DELTA:
                    begin
                        index_next = index_reg + val;
                        phase_next = PH_FLAGS;
                    end
                    PH_FLAGS:
                    begin
                        if (sec_c > SEC_INSTANCE)
                        begin
                            flags_next = val;
                            phase_next = PH_CODE;
                        end
                        else
                        begin
                            push            = 1'b1;
                            res.entry_flags = val;
                        end
                    end
                    PH_CODE:
                    begin
                        push            = 1'b1;
                        res.entry_flags = flags_reg;
                        res.code_offset = val;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase

                if (push)
                begin
                    rec_cnt_next = 5'd0;
                    flags_next   = 32'd0;
                    if (ph_c != PH_HEADER)
                    begin
                        res.record_kind  = {1'b0, sec_c} + 3'd1;
                        res.member_index = index_reg;
                        remain_next      = remain_reg - 32'd1;
                        phase_next       = PH_DELTA;
                    end
                    // advance to the next section when this one is exhausted
                    if ((ph_c == PH_HEADER) || (remain_reg == 32'd1))
                    begin
                        if (srch_found)
                        begin
                            sec_next    = srch_sec;
                            remain_next = srch_sizes[srch_sec];
                            index_next  = 32'd0;
                            phase_next  = PH_DELTA;
                        end
                        else
                        begin
                            phase_next       = PH_DONE;
                            res.last_of_item = 1'b1;
                        end
                    end
                end
            end
        end

        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            // hold the new record behind the waiting one
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            sec_reg        <= 2'd0;
            acc_reg        <= 32'd0;
            pos_reg        <= 3'd0;
            remain_reg     <= 32'd0;
            index_reg      <= 32'd0;
            flags_reg      <= 32'd0;
            item_cnt_reg   <= 32'd0;
            rec_cnt_reg    <= 5'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                sizes_reg[i] <= 32'd0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            sec_reg        <= sec_next;
            acc_reg        <= acc_next;
            pos_reg        <= pos_next;
            remain_reg     <= remain_next;
            index_reg      <= index_next;
            flags_reg      <= flags_next;
            item_cnt_reg   <= item_cnt_next;
            rec_cnt_reg    <= rec_cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                sizes_reg[i] <= sizes_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- verif/class_data_uleb_stream_decoder_test.sv -----
`timescale 1ns / 1ps

module class_data_uleb_stream_decoder_test
    import cdsd_pkg::*;
();

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BYTES = 830;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [7:0] byte_q_t[$];

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    in_word_t  byte_data = '0;
    logic      rec_valid;
    logic      rec_ready = 1'b0;
    out_word_t rec_data;

    class_data_uleb_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_data   (rec_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Decoder state as seen by the predictor
    phase_t      parse_state;
    logic [1:0]  cur_section;
    logic [31:0] value_acc;
    logic [2:0]  value_pos;
    logic [31:0] section_count [4];
    logic [31:0] entries_left;
    logic [31:0] member_sum;
    logic [31:0] flags_held;
    logic [31:0] item_bytes;
    logic [4:0]  rec_bytes;

    out_word_t pending_records[$];
    int        error_count = 0;
    int        bytes_sent = 0;
    int        cycle_count = 0;
    bit        tx_idle = 1'b0;
    bit        rx_idle = 1'b0;
    int        rx_hold = 0;

    task automatic flag_error(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic void clear_parser();
        parse_state = PH_IDLE;
        cur_section = SEC_STATIC;
        value_acc = '0;
        value_pos = '0;
        for (int s = 0; s < 4; s++)
            section_count[s] = '0;
        entries_left = '0;
        member_sum = '0;
        flags_held = '0;
        item_bytes = '0;
        rec_bytes = '0;
    endfunction

    // Open the first non-empty section at or after 'from'; 1 when the item is finished
    function automatic bit enter_section(int from);
        for (int s = from; s < 4; s++)
        begin
            if (section_count[s] != 0)
            begin
                cur_section = s[1:0];
                entries_left = section_count[s];
                member_sum = '0;
                parse_state = PH_DELTA;
                return 1'b0;
            end
        end
        parse_state = PH_DONE;
        return 1'b1;
    endfunction

    task automatic decode_byte(logic [7:0] b, bit first);
        logic [31:0] val;
        bit          done;
        out_word_t   r;
        if (first)
        begin
            clear_parser();
            parse_state = PH_HEADER;
        end
        if (parse_state == PH_IDLE || parse_state == PH_DONE)
            return;
        item_bytes = item_bytes + 32'd1;
        rec_bytes = rec_bytes + 5'd1;
        if (value_pos < 4)
        begin
            value_acc = value_acc | ({25'b0, b[6:0]} << (7 * value_pos));
            done = !b[7];
        end
        else
        begin
            // fifth byte ends the value whatever its top bit
            value_acc = value_acc | {b[3:0], 28'b0};
            done = 1'b1;
        end
        value_pos = value_pos + 3'd1;
        if (!done)
            return;
        val = value_acc;
        value_acc = '0;
        value_pos = '0;
        r = '0;
        if (parse_state == PH_HEADER)
        begin
            section_count[cur_section] = val;
            if (cur_section < SEC_VIRTUAL)
            begin
                cur_section = cur_section + 2'd1;
                return;
            end
            r.record_kind = REC_HEADER;
            r.static_count = section_count[0];
            r.instance_count = section_count[1];
            r.direct_count = section_count[2];
            r.virtual_count = section_count[3];
            r.record_bytes = rec_bytes;
            r.bytes_consumed = item_bytes;
            r.last_of_item = enter_section(0);
            rec_bytes = '0;
            pending_records.push_back(r);
            return;
        end
        if (parse_state == PH_DELTA)
        begin
            member_sum = member_sum + val;
            parse_state = PH_FLAGS;
            return;
        end
        if (parse_state == PH_FLAGS)
        begin
            flags_held = val;
            if (cur_section >= SEC_DIRECT)
            begin
                parse_state = PH_CODE;
                return;
            end
        end
        else
            r.code_offset = val;
        r.record_kind = {1'b0, cur_section} + 3'd1;
        r.member_index = member_sum;
        r.entry_flags = flags_held;
        r.record_bytes = rec_bytes;
        r.bytes_consumed = item_bytes;
        rec_bytes = '0;
        flags_held = '0;
        entries_left = entries_left - 32'd1;
        if (entries_left == 0)
            r.last_of_item = enter_section(int'(cur_section) + 1);
        else
        begin
            parse_state = PH_DELTA;
            r.last_of_item = 1'b0;
        end
        pending_records.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Called at a rising edge; returns at the rising edge where the word is taken
    task automatic send_word(logic [7:0] b, bit first);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= '{data_byte: b, first_byte: first};
        do
            @(negedge clk);
        while (!byte_ready);
        decode_byte(b, first);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic send_item(byte_q_t q);
        for (int i = 0; i < q.size(); i++)
            send_word(q[i], i == 0);
    endtask

    // Encode v in len bytes; a short len drops the high bits, a long one pads
    task automatic put_value(ref byte_q_t q, input logic [31:0] v, input int len);
        logic [3:0] junk;
        for (int i = 0; i < len; i++)
        begin
            if (i == 4)
            begin
                junk = 4'($urandom);
                q.push_back({junk, v[31:28]});
            end
            else
                q.push_back({i < len - 1, v[7 * i +: 7]});
        end
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
    endfunction

    task automatic put_random_value(ref byte_q_t q);
        int          len;
        logic [31:0] v;
        len = $urandom_range(1, 5);
        v = $urandom;
        if (len < 5)
            v = v >> (32 - 7 * len);
        if ($urandom_range(0, 4) == 0)
            v = $urandom_range(0, 3);
        put_value(q, v, len);
    endtask

    task automatic build_item(ref byte_q_t q);
        int counts [4];
        bit empty;
        empty = ($urandom_range(0, 19) == 0);
        for (int s = 0; s < 4; s++)
        begin
            counts[s] = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                counts[s] = $urandom_range(4, 6);
            if (empty)
                counts[s] = 0;
            put_value(q, counts[s], pick_len());
        end
        for (int s = 0; s < 4; s++)
        begin
            for (int e = 0; e < counts[s]; e++)
            begin
                put_random_value(q);
                put_random_value(q);
                if (s >= 2)
                    put_random_value(q);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rx_idle)
            rec_ready <= 1'b1;
        else if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else
        begin
            rec_ready <= 1'($urandom_range(0, 1));
            rx_hold <= pick_gap();
        end
    end

    always @(negedge clk)
    begin : record_check
        out_word_t want;
        if (rst_n && rec_valid && rec_ready)
        begin
            if (pending_records.size() == 0)
                flag_error($sformatf("record kind %0d with none pending", rec_data.record_kind));
            else
            begin
                want = pending_records.pop_front();
                check_field("record_kind", 32'(rec_data.record_kind),
                            32'(want.record_kind));
                check_field("member_index", rec_data.member_index, want.member_index);
                check_field("entry_flags", rec_data.entry_flags, want.entry_flags);
                check_field("code_offset", rec_data.code_offset, want.code_offset);
                check_field("static_count", rec_data.static_count, want.static_count);
                check_field("instance_count", rec_data.instance_count, want.instance_count);
                check_field("direct_count", rec_data.direct_count, want.direct_count);
                check_field("virtual_count", rec_data.virtual_count, want.virtual_count);
                check_field("record_bytes", 32'(rec_data.record_bytes),
                            32'(want.record_bytes));
                check_field("bytes_consumed", rec_data.bytes_consumed, want.bytes_consumed);
                check_field("last_of_item", 32'(rec_data.last_of_item),
                            32'(want.last_of_item));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drop bytes that arrive before any item is open
    task automatic test_bytes_before_item();
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
    endtask

    // All four counts zero: the header ends the item, trailing byte is dropped
    task automatic test_empty_item();
        send_item('{8'h00, 8'h00, 8'h00, 8'h00});
        send_word(8'hAA, 1'b0);
    endtask

    // Skip the empty instance section; widest delta, padded code offset
    task automatic test_all_sections();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item('{8'h01, 8'h00, 8'h01, 8'h01,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                    8'h01, 8'h7F, 8'h80, 8'h00,
                    8'h00, 8'h01, 8'h02});
    endtask

    // Restart in the middle of a value
    task automatic test_restart();
        send_item('{8'h01, 8'h80});
        send_item('{8'h00, 8'h00, 8'h00, 8'h00});
        tx_idle = 1'b0;
        rx_idle = 1'b0;
    endtask

    task automatic test_random_items();
        byte_q_t q;
        int      kind;
        int      mode;
        int      cut;
        while (bytes_sent < RANDOM_BYTES)
        begin
            // cycle through the four idling combinations
            mode = (bytes_sent / 150) % 4;
            tx_idle = mode[0];
            rx_idle = mode[1];
            kind = $urandom_range(0, 99);
            q.delete();
            if (kind < 85)
            begin
                build_item(q);
                send_item(q);
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
            end
            else if (kind < 95)
            begin
                build_item(q);
                cut = $urandom_range(1, q.size());
                while (q.size() > cut)
                    void'(q.pop_back());
                send_item(q);
            end
            else
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bytes_before_item();
        test_empty_item();
        test_all_sections();
        test_restart();
        test_random_items();
        byte_valid <= 1'b0;
        rx_idle = 1'b1;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
